FILE: src/rag_pkg.sv
`default_nettype none
package rag_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int MAG_WIDTH   = 2 * FIELD_WIDTH;
   localparam int ACT_WIDTH   = 3;

   localparam logic [ACT_WIDTH-1:0] ACT_LOAD = 3'd0;
   localparam logic [ACT_WIDTH-1:0] ACT_ADD  = 3'd1;
   localparam logic [ACT_WIDTH-1:0] ACT_SUB  = 3'd2;
   localparam logic [ACT_WIDTH-1:0] ACT_MUL  = 3'd3;
   localparam logic [ACT_WIDTH-1:0] ACT_DIV  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DEC,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_ADD,
      S_RED,
      S_WAIT,
      S_CHK
   } state_type;

   typedef enum logic [1:0] {
      G_IDLE,
      G_GCD,
      G_DIV,
      G_FIN
   } gcd_state_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] a;
      logic [FIELD_WIDTH-1:0] b;
      logic                   neg;
   } mul_op_type;

endpackage
`default_nettype wire

FILE: src/rag_mul.sv
`default_nettype none
module rag_mul (
   input  wire                            clock,
   input  rag_pkg::mul_op_type            op,
   output logic [rag_pkg::MAG_WIDTH-1:0]  prod_mag,
   output logic                           prod_neg
);

   logic [rag_pkg::MAG_WIDTH-1:0] prod_ff;
   logic                          neg_ff;

   always_ff @(posedge clock) begin
      prod_ff <= {{rag_pkg::FIELD_WIDTH{1'b0}}, op.a} * {{rag_pkg::FIELD_WIDTH{1'b0}}, op.b};
      neg_ff  <= op.neg;
   end

   assign prod_mag = prod_ff;
   assign prod_neg = neg_ff && (prod_ff != '0);

endmodule
`default_nettype wire

FILE: src/rag_gcd.sv
`default_nettype none
module rag_gcd #(
   parameter int MagWidth = rag_pkg::MAG_WIDTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire  [MagWidth-1:0] x,
   input  wire  [MagWidth-1:0] y,
   output logic                done,
   output logic [MagWidth-1:0] qx,
   output logic [MagWidth-1:0] qy
);

   localparam int KW = $clog2(MagWidth + 1);
   localparam int CW = $clog2(MagWidth);

   rag_pkg::gcd_state_type state_ff, state_in;

   logic [MagWidth-1:0] a_ff, b_ff, g_ff, xs_ff, ys_ff, dvd_ff, rem_ff, qx_ff, qy_ff;
   logic [KW-1:0]       k_ff;
   logic [CW-1:0]       cnt_ff;
   logic                sel_y_ff;

   // shared subtractor: a - b during the search, partial remainder - g while dividing
   logic [MagWidth:0]   sub_a, sub_b;
   logic [MagWidth+1:0] diff;
   logic                ge;
   logic [MagWidth-1:0] gv;
   logic                last_bit;

   always_comb begin
      if (state_ff == rag_pkg::G_DIV) begin
         sub_a = {rem_ff, dvd_ff[MagWidth-1]};
         sub_b = {1'b0, g_ff};
      end else begin
         sub_a = {1'b0, a_ff};
         sub_b = {1'b0, b_ff};
      end
      diff = {1'b0, sub_a} - {1'b0, sub_b};
      ge   = !diff[MagWidth+1];
   end

   assign gv       = ((a_ff == '0) ? b_ff : a_ff) << k_ff;
   assign last_bit = (cnt_ff == CW'(MagWidth - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rag_pkg::G_IDLE: if (start) state_in = rag_pkg::G_GCD;
         rag_pkg::G_GCD: begin
            if (a_ff == '0 || b_ff == '0) begin
               state_in = (gv == '0) ? rag_pkg::G_FIN : rag_pkg::G_DIV;
            end
         end
         rag_pkg::G_DIV: if (last_bit && sel_y_ff) state_in = rag_pkg::G_FIN;
         rag_pkg::G_FIN: state_in = rag_pkg::G_IDLE;
         default:        state_in = rag_pkg::G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rag_pkg::G_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rag_pkg::G_IDLE: begin
            a_ff  <= x;
            b_ff  <= y;
            xs_ff <= x;
            ys_ff <= y;
            k_ff  <= '0;
         end
         rag_pkg::G_GCD: begin
            priority if (a_ff == '0 || b_ff == '0) begin
               g_ff     <= gv;
               dvd_ff   <= xs_ff;
               rem_ff   <= '0;
               cnt_ff   <= '0;
               sel_y_ff <= 1'b0;
               qx_ff    <= xs_ff;
               qy_ff    <= ys_ff;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_ff <= a_ff >> 1;
               b_ff <= b_ff >> 1;
               k_ff <= k_ff + KW'(1);
            end else if (!a_ff[0]) begin
               a_ff <= a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_ff <= b_ff >> 1;
            end else if (ge) begin
               a_ff <= diff[MagWidth-1:0];
            end else begin
               b_ff <= b_ff - a_ff;
            end
         end
         rag_pkg::G_DIV: begin
            rem_ff <= ge ? diff[MagWidth-1:0] : sub_a[MagWidth-1:0];
            dvd_ff <= {dvd_ff[MagWidth-2:0], ge};
            cnt_ff <= cnt_ff + CW'(1);
            if (last_bit) begin
               if (sel_y_ff) begin
                  qy_ff <= {dvd_ff[MagWidth-2:0], ge};
               end else begin
                  qx_ff    <= {dvd_ff[MagWidth-2:0], ge};
                  dvd_ff   <= ys_ff;
                  rem_ff   <= '0;
                  sel_y_ff <= 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign done = (state_ff == rag_pkg::G_FIN);
   assign qx   = qx_ff;
   assign qy   = qy_ff;

endmodule
`default_nettype wire

FILE: src/rational_accumulator_gcd_unit.sv
// Flow: load and the unused action codes go straight from decode to the result check;
// multiply and divide first take two products from the shared multiplier.
// Add and subtract take three products when the denominators differ, then wait on the
// binary gcd search and the two 64-step quotient passes on the shared subtractor; the
// quotient passes are skipped when the numerator and the denominator are both zero.
// Throughput: one item at a time; a new beat is taken once the result is written to the output register.
// Reset: synchronous, active high; accumulator returns to 0 over 1, no result pending.
`default_nettype none
module rational_accumulator_gcd_unit #(
   parameter int VALUE_WIDTH = rag_pkg::VALUE_WIDTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // action [2:0], operand_numerator [34:3], operand_denominator [66:35], zero pad
   input  wire  [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // result_numerator [31:0], result_denominator [63:32], overflow [64],
   // zero_denominator [65], zero pad
   output logic [71:0] rsp_tdata
);

   localparam int FW  = rag_pkg::FIELD_WIDTH;
   localparam int MW  = rag_pkg::MAG_WIDTH;
   localparam int EFF = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 8) ? 8 : VALUE_WIDTH);
   localparam logic [MW-1:0] LIM = MW'(1) << (EFF - 1);

   rag_pkg::state_type state_ff, state_in;

   logic [FW-1:0]                 acc_num_ff, acc_den_ff;
   logic [rag_pkg::ACT_WIDTH-1:0] act_ff;
   logic [FW-1:0]                 onum_ff, oden_ff;
   logic [MW-1:0]                 t_mag_ff, u_mag_ff, rn_mag_ff, rd_mag_ff;
   logic                          t_neg_ff, u_neg_ff, rn_neg_ff, rd_neg_ff, eq_ff;
   logic [FW-1:0]                 rsp_num_ff, rsp_den_ff;
   logic                          rsp_ovf_ff, rsp_zd_ff, rsp_valid_ff;

   logic                          an_neg, ad_neg, on_neg, od_neg, oth_neg;
   logic [FW-1:0]                 an_mag, ad_mag, on_mag, od_mag;
   rag_pkg::mul_op_type           mop;
   logic [MW-1:0]                 prod_mag, sum_mag, qx, qy;
   logic                          prod_neg, sum_neg, gcd_start, gcd_done;
   logic                          is_addsub, act_ok, fit_ok, slot_free, commit;
   logic [FW-1:0]                 new_num, new_den;

   function automatic logic [FW-1:0] mag32(input logic [FW-1:0] v);
      return v[FW-1] ? (FW'(0) - v) : v;
   endfunction

   function automatic logic fits(input logic neg, input logic [MW-1:0] mag);
      return neg ? (mag <= LIM) : (mag < LIM);
   endfunction

   function automatic logic [FW-1:0] to_bits(input logic neg, input logic [MW-1:0] mag);
      logic [MW-1:0] v;
      v = neg ? (MW'(0) - mag) : mag;
      return v[FW-1:0];
   endfunction

   assign an_neg  = acc_num_ff[FW-1];
   assign ad_neg  = acc_den_ff[FW-1];
   assign on_neg  = onum_ff[FW-1];
   assign od_neg  = oden_ff[FW-1];
   assign an_mag  = mag32(acc_num_ff);
   assign ad_mag  = mag32(acc_den_ff);
   assign on_mag  = mag32(onum_ff);
   assign od_mag  = mag32(oden_ff);
   assign oth_neg = (act_ff == rag_pkg::ACT_SUB) ? (on_neg ^ (on_mag != '0)) : on_neg;

   assign is_addsub = (act_ff == rag_pkg::ACT_ADD) || (act_ff == rag_pkg::ACT_SUB);
   assign act_ok    = (act_ff <= rag_pkg::ACT_DIV);

   // signed-magnitude add of the two staged terms
   always_comb begin
      if (t_neg_ff == u_neg_ff) begin
         sum_mag = t_mag_ff + u_mag_ff;
         sum_neg = t_neg_ff;
      end else if (t_mag_ff >= u_mag_ff) begin
         sum_mag = t_mag_ff - u_mag_ff;
         sum_neg = t_neg_ff;
      end else begin
         sum_mag = u_mag_ff - t_mag_ff;
         sum_neg = u_neg_ff;
      end
      if (sum_mag == '0) sum_neg = 1'b0;
   end

   assign fit_ok    = fits(rn_neg_ff, rn_mag_ff) && fits(rd_neg_ff, rd_mag_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign commit    = act_ok && fit_ok;
   assign new_num   = commit ? to_bits(rn_neg_ff, rn_mag_ff) : acc_num_ff;
   assign new_den   = commit ? to_bits(rd_neg_ff, rd_mag_ff) : acc_den_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rag_pkg::S_IDLE: if (req_tvalid) state_in = rag_pkg::S_DEC;
         rag_pkg::S_DEC: begin
            priority if (!act_ok || act_ff == rag_pkg::ACT_LOAD) begin
               state_in = rag_pkg::S_CHK;
            end else if (is_addsub && oden_ff == acc_den_ff) begin
               state_in = rag_pkg::S_ADD;
            end else begin
               state_in = rag_pkg::S_MUL0;
            end
         end
         rag_pkg::S_MUL0: state_in = rag_pkg::S_MUL1;
         rag_pkg::S_MUL1: state_in = rag_pkg::S_MUL2;
         rag_pkg::S_MUL2: state_in = rag_pkg::S_ADD;
         rag_pkg::S_ADD:  state_in = is_addsub ? rag_pkg::S_RED : rag_pkg::S_CHK;
         rag_pkg::S_RED:  state_in = rag_pkg::S_WAIT;
         rag_pkg::S_WAIT: if (gcd_done) state_in = rag_pkg::S_CHK;
         rag_pkg::S_CHK:  if (slot_free) state_in = rag_pkg::S_IDLE;
         default:         state_in = rag_pkg::S_IDLE;
      endcase
   end

   // outputs and multiplier operand select
   always_comb begin
      req_tready = (state_ff == rag_pkg::S_IDLE);
      gcd_start  = (state_ff == rag_pkg::S_RED);
      mop.a      = ad_mag;
      mop.b      = od_mag;
      mop.neg    = ad_neg ^ od_neg;
      unique case (state_ff)
         rag_pkg::S_MUL0: begin
            mop.a = an_mag;
            if (act_ff == rag_pkg::ACT_MUL) begin
               mop.b   = on_mag;
               mop.neg = an_neg ^ on_neg;
            end else begin
               mop.b   = od_mag;
               mop.neg = an_neg ^ od_neg;
            end
         end
         rag_pkg::S_MUL1: begin
            priority if (is_addsub) begin
               mop.a   = on_mag;
               mop.b   = ad_mag;
               mop.neg = oth_neg ^ ad_neg;
            end else if (act_ff == rag_pkg::ACT_DIV) begin
               mop.a   = ad_mag;
               mop.b   = on_mag;
               mop.neg = ad_neg ^ on_neg;
            end else begin
               mop.a   = ad_mag;
               mop.b   = od_mag;
               mop.neg = ad_neg ^ od_neg;
            end
         end
         default: begin
         end
      endcase
   end

   rag_mul u_mul (
      .clock    (clock),
      .op       (mop),
      .prod_mag (prod_mag),
      .prod_neg (prod_neg)
   );

   rag_gcd #(.MagWidth(MW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (gcd_start),
      .x     (rn_mag_ff),
      .y     (rd_mag_ff),
      .done  (gcd_done),
      .qx    (qx),
      .qy    (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rag_pkg::S_IDLE;
         acc_num_ff   <= '0;
         acc_den_ff   <= FW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rag_pkg::S_CHK && slot_free) begin
            acc_num_ff   <= new_num;
            acc_den_ff   <= new_den;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         rag_pkg::S_IDLE: begin
            act_ff  <= req_tdata[2:0];
            onum_ff <= req_tdata[34:3];
            oden_ff <= req_tdata[66:35];
         end
         rag_pkg::S_DEC: begin
            eq_ff     <= (oden_ff == acc_den_ff);
            rn_mag_ff <= {{FW{1'b0}}, on_mag};
            rn_neg_ff <= on_neg;
            rd_mag_ff <= {{FW{1'b0}}, od_mag};
            rd_neg_ff <= od_neg;
            t_mag_ff  <= {{FW{1'b0}}, an_mag};
            t_neg_ff  <= an_neg;
            u_mag_ff  <= {{FW{1'b0}}, on_mag};
            u_neg_ff  <= oth_neg;
            if (is_addsub) begin
               rd_mag_ff <= {{FW{1'b0}}, ad_mag};
               rd_neg_ff <= ad_neg;
            end
         end
         rag_pkg::S_MUL1: begin
            t_mag_ff <= prod_mag;
            t_neg_ff <= prod_neg;
         end
         rag_pkg::S_MUL2: begin
            u_mag_ff <= prod_mag;
            u_neg_ff <= prod_neg;
         end
         rag_pkg::S_ADD: begin
            if (is_addsub) begin
               rn_mag_ff <= sum_mag;
               rn_neg_ff <= sum_neg;
               if (!eq_ff) begin
                  rd_mag_ff <= prod_mag;
                  rd_neg_ff <= prod_neg;
               end
            end else begin
               rn_mag_ff <= t_mag_ff;
               rn_neg_ff <= t_neg_ff;
               rd_mag_ff <= u_mag_ff;
               rd_neg_ff <= u_neg_ff;
            end
         end
         rag_pkg::S_WAIT: begin
            if (gcd_done) begin
               rn_mag_ff <= qx;
               rd_mag_ff <= qy;
            end
         end
         rag_pkg::S_CHK: begin
            if (slot_free) begin
               rsp_num_ff <= new_num;
               rsp_den_ff <= new_den;
               rsp_ovf_ff <= act_ok && !fit_ok;
               rsp_zd_ff  <= (new_den == '0);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_zd_ff, rsp_ovf_ff, rsp_den_ff, rsp_num_ff};

   // one beat in flight: no second accept right after the first
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken twice in a row");

   // accumulator only moves when a result is handed to the output register
   a_acc_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(acc_den_ff) |-> ($past(state_ff == rag_pkg::S_CHK) || $past(reset)))
      else $error("accumulator changed outside commit");

   // reduction unit finishes only while the sequencer waits for it
   a_gcd_done: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> (state_ff == rag_pkg::S_WAIT))
      else $error("reduction done while not waiting");

endmodule
`default_nettype wire
